// ----- hdl/string_hash_set_open_addressing_assert.svh -----
// ---------------------------------------------------------------------------
// string_hash_set_open_addressing_assert.svh
// Assertion macros used by the hash set top level.
// ---------------------------------------------------------------------------
`ifndef STRING_HASH_SET_OPEN_ADDRESSING_ASSERT_SVH
`define STRING_HASH_SET_OPEN_ADDRESSING_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SHSET_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("shset check failed");

// Next-cycle implication, disabled during reset
`define SHSET_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("shset check failed");

`endif

// ----- hdl/shset_pkg.sv -----
// ---------------------------------------------------------------------------
// shset_pkg
// Shared types and constants of the open-addressing string hash set.
// ---------------------------------------------------------------------------
package shset_pkg;

   // Field widths
   localparam int REQ_W   = 2;
   localparam int KEY_W   = 64;
   localparam int LEN_W   = 4;
   localparam int HASH_W  = 32;
   localparam int STATE_W = 2;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
   localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;
   localparam logic [REQ_W-1:0] REQ_NOP    = 2'd3;

   // Slot state codes
   localparam logic [STATE_W-1:0] SLOT_EMPTY   = 2'd0;
   localparam logic [STATE_W-1:0] SLOT_FULL    = 2'd1;
   localparam logic [STATE_W-1:0] SLOT_DELETED = 2'd2;

   // Controller to datapath commands
   typedef struct packed {
      logic clear;        // write one empty slot of the clearing pass
      logic load;         // capture an accepted request
      logic hash_step;    // one Horner step
      logic probe_start;  // home slot from the hash
      logic rd_en;        // read the current slot
      logic check;        // evaluate the slot just read
      logic commit;       // table update and result capture
      logic out_load;     // move result into the output register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_last;
      logic req_nop;
      logic hash_done;
      logic match;
      logic slot_empty;
      logic probe_last;
      logic out_busy;
   } stat_type;

endpackage

// ----- hdl/string_hash_set_open_addressing.sv -----
// A request transfer is followed by hashing over the clamped key length, then a probe
// walk (one RAM read and one compare per slot probed); one request is in flight at a time.
// A waiting response does not block the next request transfer. Unused request codes
// skip hashing and probing.
// Reset: synchronous; a clearing pass then writes every slot empty, with req_ready
// low throughout.
// ---------------------------------------------------------------------------
// string_hash_set_open_addressing
// String set in an open-addressing hash table with triangular probing.
// ---------------------------------------------------------------------------
`include "string_hash_set_open_addressing_assert.svh"

module string_hash_set_open_addressing #(
   parameter int TABLE_SIZE = 256,
   parameter int MAX_CHARS  = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [shset_pkg::REQ_W-1:0] req_type,
   input  logic [shset_pkg::KEY_W-1:0] req_key_chars,
   input  logic [shset_pkg::LEN_W-1:0] req_key_len,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_ok,
   output logic                        rsp_table_full
);
   import shset_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   shset_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   shset_dp #(
      .TABLE_SIZE (TABLE_SIZE),
      .MAX_CHARS  (MAX_CHARS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_type       (req_type),
      .req_key_chars  (req_key_chars),
      .req_key_len    (req_key_len),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ok         (rsp_ok),
      .rsp_table_full (rsp_table_full)
   );

   // one request in flight: no second transfer right after one
   `SHSET_ASSERT_NEXT(a_single_flight, clock, reset, req_valid && req_ready, !req_ready)
   // a failed add never reports success
   `SHSET_ASSERT_NOW(a_full_not_ok, clock, reset, rsp_valid && rsp_table_full, !rsp_ok)
   // no request is taken while the table is being cleared
   `SHSET_ASSERT_NOW(a_clear_blocks, clock, reset, cmd.clear, !req_ready)
   // a new result is only loaded when the output register can take it
   `SHSET_ASSERT_NOW(a_out_free, clock, reset, cmd.out_load, !rsp_valid || rsp_ready)

endmodule

// ----- hdl/shset_ram.sv -----
// ---------------------------------------------------------------------------
// shset_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module shset_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/shset_dp.sv -----
// ---------------------------------------------------------------------------
// shset_dp
// Datapath: request registers, Horner hash, probe walk, slot table, result.
// ---------------------------------------------------------------------------
module shset_dp #(
   parameter int TABLE_SIZE = 256,
   parameter int MAX_CHARS  = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  shset_pkg::cmd_type          cmd,
   output shset_pkg::stat_type         stat,
   input  logic [shset_pkg::REQ_W-1:0] req_type,
   input  logic [shset_pkg::KEY_W-1:0] req_key_chars,
   input  logic [shset_pkg::LEN_W-1:0] req_key_len,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_ok,
   output logic                        rsp_table_full
);
   import shset_pkg::*;

   localparam int IDX_W   = $clog2(TABLE_SIZE);
   localparam int CIDX_W  = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
   localparam int SKEY_W  = 8 * MAX_CHARS;
   localparam int WORD_W  = STATE_W + LEN_W + SKEY_W;

   // request registers
   logic [REQ_W-1:0]               type_ff;
   logic [MAX_CHARS-1:0][7:0]      key_ff;
   logic [LEN_W-1:0]               len_ff;
   logic [LEN_W-1:0]               len_clamp;
   logic [MAX_CHARS-1:0][7:0]      key_masked;

   // hash and probe registers
   logic [HASH_W-1:0]              hash_ff;
   logic [LEN_W-1:0]               hcnt_ff;
   logic [IDX_W-1:0]               slot_ff;
   logic [IDX_W-1:0]               step_ff;
   logic [IDX_W-1:0]               free_ff;
   logic                           free_vld_ff;
   logic                           found_ff;
   logic [IDX_W-1:0]               clr_ff;

   // result registers
   logic                           res_ok_ff;
   logic                           res_full_ff;
   logic                           rsp_valid_ff;
   logic                           rsp_ok_ff;
   logic                           rsp_full_ff;

   // memory ports
   logic                           wr_en;
   logic [IDX_W-1:0]               wr_addr;
   logic [WORD_W-1:0]              wr_data;
   logic [WORD_W-1:0]              rd_data;
   logic [STATE_W-1:0]             rd_state;
   logic [LEN_W-1:0]               rd_len;
   logic [SKEY_W-1:0]              rd_key;

   // commit decode
   logic                           do_insert;
   logic                           do_delete;

   // length clamp and byte masking of the incoming key
   always_comb begin
      len_clamp = (req_key_len > LEN_W'(MAX_CHARS)) ? LEN_W'(MAX_CHARS) : req_key_len;
      for (int b = 0; b < MAX_CHARS; b++) begin
         key_masked[b] = (LEN_W'(b) < len_clamp) ? req_key_chars[8*b +: 8] : 8'h00;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff <= req_type;
         key_ff  <= key_masked;
         len_ff  <= len_clamp;
      end
   end

   // Horner hash, h = h*113 + c, as shift-adds (113 = 64 + 32 + 16 + 1)
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hash_ff <= '0;
         hcnt_ff <= '0;
      end else if (cmd.hash_step) begin
         hash_ff <= (hash_ff << 6) + (hash_ff << 5) + (hash_ff << 4) + hash_ff
                    + HASH_W'(key_ff[hcnt_ff[CIDX_W-1:0]]);
         hcnt_ff <= hcnt_ff + 1'b1;
      end
   end

   // slot word fields
   assign rd_state = rd_data[WORD_W-1 -: STATE_W];
   assign rd_len   = rd_data[SKEY_W +: LEN_W];
   assign rd_key   = rd_data[SKEY_W-1:0];

   // triangular probe walk
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         free_vld_ff <= 1'b0;
         found_ff    <= 1'b0;
      end else if (cmd.probe_start) begin
         slot_ff <= hash_ff[IDX_W-1:0];
         step_ff <= '0;
      end else if (cmd.check) begin
         found_ff <= stat.match;
         if (!free_vld_ff && rd_state != SLOT_FULL) begin
            free_ff     <= slot_ff;
            free_vld_ff <= 1'b1;
         end
         if (!stat.match && !stat.slot_empty) begin
            slot_ff <= slot_ff + step_ff + 1'b1;
            step_ff <= step_ff + 1'b1;
         end
      end
   end

   // clearing pass address
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // table update
   always_comb begin
      do_insert = cmd.commit && type_ff == REQ_ADD && !found_ff && free_vld_ff;
      do_delete = cmd.commit && type_ff == REQ_REMOVE && found_ff;
      wr_en     = cmd.clear || do_insert || do_delete;
      if (cmd.clear) begin
         wr_addr = clr_ff;
         wr_data = {SLOT_EMPTY, LEN_W'(0), SKEY_W'(0)};
      end else if (do_insert) begin
         wr_addr = free_ff;
         wr_data = {SLOT_FULL, len_ff, key_ff};
      end else begin
         wr_addr = slot_ff;
         wr_data = {SLOT_DELETED, len_ff, key_ff};
      end
   end

   shset_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_SIZE)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (slot_ff),
      .rd_data (rd_data)
   );

   // result of the finished walk
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         res_ok_ff   <= do_insert || do_delete || (type_ff == REQ_QUERY && found_ff);
         res_full_ff <= type_ff == REQ_ADD && !found_ff && !free_vld_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ok_ff   <= res_ok_ff;
         rsp_full_ff <= res_full_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_table_full = rsp_full_ff;

   // status to the controller
   always_comb begin
      stat.clear_last = &clr_ff;
      stat.req_nop    = type_ff == REQ_NOP;
      stat.hash_done  = hcnt_ff == len_ff;
      stat.match      = rd_state == SLOT_FULL && rd_key == key_ff && rd_len == len_ff;
      stat.slot_empty = rd_state == SLOT_EMPTY;
      stat.probe_last = &step_ff;
      stat.out_busy   = rsp_valid_ff && !rsp_ready;
   end

endmodule

// ----- hdl/shset_ctrl.sv -----
// ---------------------------------------------------------------------------
// shset_ctrl
// Controller: clearing pass, hashing, probe walk sequencing and commit.
// ---------------------------------------------------------------------------
module shset_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  shset_pkg::stat_type stat,
   output shset_pkg::cmd_type  cmd
);
   import shset_pkg::*;

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_HASH  = 7'b0000100,
      S_READ  = 7'b0001000,
      S_CHECK = 7'b0010000,
      S_WRITE = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (stat.req_nop) begin
               state_in = S_WRITE;
            end else if (stat.hash_done) begin
               cmd.probe_start = 1'b1;
               state_in        = S_READ;
            end else begin
               cmd.hash_step = 1'b1;
            end
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            if (stat.match || stat.slot_empty || stat.probe_last) begin
               state_in = S_WRITE;
            end else begin
               state_in = S_READ;
            end
         end
         S_WRITE: begin
            cmd.commit = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!stat.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- sim/string_hash_set_open_addressing_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// string_hash_set_open_addressing_checker
// Watches both channels, keeps a shadow of the hash table and compares each
// response transfer, field by field, with the oldest predicted outcome.
// ---------------------------------------------------------------------------
module string_hash_set_open_addressing_checker #(
   parameter int TABLE_SIZE = 256,
   parameter int MAX_CHARS  = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [shset_pkg::REQ_W-1:0] req_type,
   input  logic [shset_pkg::KEY_W-1:0] req_key_chars,
   input  logic [shset_pkg::LEN_W-1:0] req_key_len,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic                        rsp_ok,
   input  logic                        rsp_table_full,
   output int                          fail_count,
   output int                          pending,
   output int                          checked,
   output int                          full_seen
);
   import shset_pkg::*;

   localparam logic [HASH_W-1:0] HORNER_MUL = 113;

   typedef struct packed {
      logic ok;
      logic table_full;
   } set_outcome_type;

   // Shadow table
   logic [KEY_W-1:0]   shadow_chars [TABLE_SIZE];
   logic [LEN_W-1:0]   shadow_len   [TABLE_SIZE];
   logic [STATE_W-1:0] shadow_state [TABLE_SIZE];

   set_outcome_type awaited_outcomes [$];
   int mismatches = 0;
   int rsp_seen   = 0;
   int full_count = 0;

   assign fail_count = mismatches;
   assign checked    = rsp_seen;
   assign full_seen  = full_count;

   initial pending = 0;

   // Hash, probe walk and table update for one request
   function automatic set_outcome_type apply_set_op(input logic [REQ_W-1:0] op,
                                                    input logic [KEY_W-1:0] raw_chars,
                                                    input logic [LEN_W-1:0] raw_len);
      int unsigned      n;
      logic [KEY_W-1:0] k;
      logic [HASH_W-1:0] h;
      int               slot;
      int               hit;
      int               free_slot;
      int               i;
      set_outcome_type  res;
      res = '0;
      n = (raw_len > MAX_CHARS) ? MAX_CHARS : raw_len;
      // bytes past the length never count
      k = raw_chars;
      for (i = n; i < KEY_W / 8; i++) k[8*i +: 8] = '0;
      if (op == REQ_NOP) return res;
      h = '0;
      for (i = 0; i < n; i++) h = h * HORNER_MUL + k[8*i +: 8];
      slot      = int'(h & (TABLE_SIZE - 1));
      hit       = -1;
      free_slot = -1;
      // triangular walk: stops at a match or an empty slot
      for (i = 0; i < TABLE_SIZE; i++) begin
         if (shadow_state[slot] == SLOT_FULL && shadow_chars[slot] == k &&
             shadow_len[slot] == n) begin
            hit = slot;
            break;
         end
         if (shadow_state[slot] != SLOT_FULL) begin
            if (free_slot < 0) free_slot = slot;
            if (shadow_state[slot] == SLOT_EMPTY) break;
         end
         slot = (slot + i + 1) % TABLE_SIZE;
      end
      case (op)
         REQ_ADD: begin
            if (hit < 0) begin
               if (free_slot >= 0) begin
                  shadow_chars[free_slot] = k;
                  shadow_len[free_slot]   = LEN_W'(n);
                  shadow_state[free_slot] = SLOT_FULL;
                  res.ok = 1'b1;
               end else begin
                  res.table_full = 1'b1;
               end
            end
         end
         REQ_REMOVE: begin
            if (hit >= 0) begin
               shadow_state[hit] = SLOT_DELETED;
               res.ok = 1'b1;
            end
         end
         REQ_QUERY: res.ok = (hit >= 0);
         default: ;
      endcase
      return res;
   endfunction

   // Predict on request transfers, compare on response transfers
   always @(posedge clock) begin : watch
      set_outcome_type want;
      if (reset) begin
         for (int s = 0; s < TABLE_SIZE; s++) shadow_state[s] = SLOT_EMPTY;
         awaited_outcomes.delete();
         pending <= 0;
      end else begin
         if (req_valid && req_ready)
            awaited_outcomes.push_back(apply_set_op(req_type, req_key_chars, req_key_len));
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (awaited_outcomes.size() == 0) begin
               $error("response transfer with no request outstanding");
               mismatches++;
            end else begin
               want = awaited_outcomes.pop_front();
               if (want.table_full) full_count++;
               if (rsp_ok !== want.ok) begin
                  $error("rsp_ok: expected %0b, actual %0b", want.ok, rsp_ok);
                  mismatches++;
               end
               if (rsp_table_full !== want.table_full) begin
                  $error("rsp_table_full: expected %0b, actual %0b",
                         want.table_full, rsp_table_full);
                  mismatches++;
               end
            end
         end
         pending <= awaited_outcomes.size();
      end
   end

endmodule

// ----- sim/string_hash_set_open_addressing_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// string_hash_set_open_addressing_tb
// Drives add, remove and query requests into the hash set: directed corner
// keys, a random mix over a small key pool, a fill past the point where adds are refused,
// then churn on the full table. Response checking lives in the checker.
// ---------------------------------------------------------------------------
module string_hash_set_open_addressing_tb;
   import shset_pkg::*;

   localparam int TABLE_SIZE  = 256;
   localparam int MAX_CHARS   = 8;
   localparam int N_DIRECTED  = 25;
   localparam int N_MIX       = 190;
   localparam int N_FILL      = 285;
   localparam int N_CHURN     = 50;
   localparam int TOTAL_ITEMS = N_DIRECTED + N_MIX + N_FILL + N_CHURN;
   localparam int POOL_SIZE   = 24;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 64;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_ready;
   logic [REQ_W-1:0]   req_type       = REQ_NOP;
   logic [KEY_W-1:0]   req_key_chars  = '0;
   logic [LEN_W-1:0]   req_key_len    = '0;
   logic               rsp_valid;
   logic               rsp_ready      = 1'b0;
   logic               rsp_ok;
   logic               rsp_table_full;

   int fail_count;
   int pending;
   int checked;
   int full_seen;

   int   sent             = 0;
   int   idle_phase       = 0;
   logic hold_off_request = 1'b0;
   logic hold_off_done    = 1'b0;
   logic hold_active      = 1'b0;

   always #2 clock = ~clock;

   string_hash_set_open_addressing #(
      .TABLE_SIZE(TABLE_SIZE),
      .MAX_CHARS (MAX_CHARS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_key_chars (req_key_chars),
      .req_key_len   (req_key_len),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_ok        (rsp_ok),
      .rsp_table_full(rsp_table_full)
   );

   string_hash_set_open_addressing_checker #(
      .TABLE_SIZE(TABLE_SIZE),
      .MAX_CHARS (MAX_CHARS)
   ) outcome_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_key_chars (req_key_chars),
      .req_key_len   (req_key_len),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_ok        (rsp_ok),
      .rsp_table_full(rsp_table_full),
      .fail_count    (fail_count),
      .pending       (pending),
      .checked       (checked),
      .full_seen     (full_seen)
   );

   // One request transfer; called and returns at a falling edge
   task automatic offer_request(input logic [REQ_W-1:0] op,
                                input logic [KEY_W-1:0] chars,
                                input logic [LEN_W-1:0] len);
      int gap_pct;
      gap_pct = hold_active ? 0 : (idle_phase == 0) ? 20 : (idle_phase == 1) ? 61 : 0;
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= op;
      req_key_chars <= chars;
      req_key_len   <= len;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      sent++;
      idle_phase = (sent * 3) / TOTAL_ITEMS;
      if (idle_phase > 2) idle_phase = 2;
   endtask

   // Response side: random stalls per phase, one long hold-off on request
   initial begin : response_sink
      int stall_pct;
      forever begin
         @(negedge clock);
         if (hold_off_request && !hold_off_done) begin
            hold_active <= 1'b1;
            rsp_ready   <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_active   <= 1'b0;
            hold_off_done = 1'b1;
         end
         stall_pct = (idle_phase == 0) ? 61 : (idle_phase == 1) ? 20 : 0;
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Stimulus and verdict
   initial begin : stimulus
      logic [KEY_W-1:0] pool_chars [POOL_SIZE];
      logic [LEN_W-1:0] pool_len   [POOL_SIZE];
      logic [KEY_W-1:0] filled_chars [$];
      logic [LEN_W-1:0] filled_len   [$];
      logic [REQ_W-1:0] op;
      logic [KEY_W-1:0] chars;
      logic [KEY_W-1:0] keep;
      logic [LEN_W-1:0] len;
      int               i;
      int               j;
      int               pick;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty key, all-ones key, clamped lengths, ignored tail bytes,
      // unused code, and a colliding pair (same Horner hash) around a tombstone
      offer_request(REQ_QUERY,  64'h0, 4'd0);
      offer_request(REQ_ADD,    64'h0, 4'd0);
      offer_request(REQ_ADD,    64'hDEAD_BEEF_0BAD_F00D, 4'd0);
      offer_request(REQ_QUERY,  64'h0, 4'd0);
      offer_request(REQ_ADD,    '1, 4'd8);
      offer_request(REQ_QUERY,  '1, 4'd15);
      offer_request(REQ_ADD,    '1, 4'd9);
      offer_request(REQ_ADD,    64'h5A5A_5A5A_5A5A_5A01, 4'd1);
      offer_request(REQ_QUERY,  64'h1, 4'd1);
      offer_request(REQ_NOP,    '1, 4'd15);
      offer_request(REQ_ADD,    64'h8010, 4'd2);
      offer_request(REQ_ADD,    64'h0F11, 4'd2);
      offer_request(REQ_REMOVE, 64'h8010, 4'd2);
      offer_request(REQ_QUERY,  64'h0F11, 4'd2);
      offer_request(REQ_QUERY,  64'h8010, 4'd2);
      offer_request(REQ_REMOVE, 64'h8010, 4'd2);
      offer_request(REQ_ADD,    64'h0F11, 4'd2);
      offer_request(REQ_ADD,    64'h8010, 4'd2);
      offer_request(REQ_REMOVE, 64'h1234_5678_0000_0000, 4'd0);
      offer_request(REQ_QUERY,  64'h0, 4'd0);
      offer_request(REQ_ADD,    64'h0, 4'd8);
      offer_request(REQ_REMOVE, '1, 4'd8);
      offer_request(REQ_NOP,    64'h0, 4'd0);
      offer_request(REQ_REMOVE, 64'hFF01, 4'd1);
      offer_request(REQ_QUERY,  64'hFFFF_FFFF_FFFF_8010, 4'd2);

      // Random mix over a small pool so adds, removes and queries hit each other
      for (i = 0; i < POOL_SIZE; i++) begin
         pool_chars[i] = {$urandom, $urandom};
         pool_len[i]   = ($urandom_range(7) == 0) ? 4'd0 : LEN_W'($urandom_range(1, 8));
      end
      hold_off_request = 1'b1;
      for (i = 0; i < N_MIX; i++) begin
         pick = $urandom_range(99);
         op = (pick < 40) ? REQ_ADD : (pick < 65) ? REQ_REMOVE :
              (pick < 95) ? REQ_QUERY : REQ_NOP;
         if ($urandom_range(99) < 15) begin
            chars = {$urandom, $urandom};
            len   = LEN_W'($urandom_range(15));
         end else begin
            j     = $urandom_range(POOL_SIZE - 1);
            chars = pool_chars[j];
            len   = pool_len[j];
            // fresh junk past the length; same key as far as the set goes
            if (len < 8 && $urandom_range(1) == 1) begin
               keep  = (64'd1 << (8 * len)) - 64'd1;
               chars = (chars & keep) | ({$urandom, $urandom} & ~keep);
            end
            if (len == 8 && $urandom_range(3) == 0) len = LEN_W'($urandom_range(9, 15));
         end
         offer_request(op, chars, len);
      end

      // Fill past capacity: the tail of these adds must be refused
      for (i = 0; i < N_FILL; i++) begin
         chars = {$urandom, $urandom};
         len   = LEN_W'($urandom_range(2, 8));
         filled_chars.push_back(chars);
         filled_len.push_back(len);
         offer_request(REQ_ADD, chars, len);
      end

      // Churn on the full table: tombstones, reuse and full-length walks
      for (i = 0; i < N_CHURN; i++) begin
         j    = $urandom_range(filled_chars.size() - 1);
         pick = $urandom_range(99);
         if (pick < 35)
            offer_request(REQ_REMOVE, filled_chars[j], filled_len[j]);
         else if (pick < 55)
            offer_request(REQ_ADD, filled_chars[j], filled_len[j]);
         else if (pick < 75)
            offer_request(REQ_ADD, {$urandom, $urandom}, LEN_W'($urandom_range(1, 8)));
         else if (pick < 90)
            offer_request(REQ_QUERY, filled_chars[j], filled_len[j]);
         else
            offer_request(REQ_QUERY, {$urandom, $urandom}, LEN_W'($urandom_range(1, 8)));
      end
      req_valid <= 1'b0;

      // Drain, then a quiet stretch to catch stray responses
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests: directed corner keys, pooled add/remove/query mix,",
               sent);
      $display("fill to capacity and churn; %0d responses checked, %0d refused as full.",
               checked, full_seen);
      if (fail_count == 0 && pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
